// ----- sv/bseg_pkg.sv -----
// Shared types and constants for the block-energy silence gate.
// No dependencies; the controller, datapath and top level use it.
`timescale 1ns / 1ps

package bseg_pkg;

    localparam int BLOCK_SIZE_DEF = 64;

    localparam int SAMPLE_W    = 16;
    localparam int ENERGY_TH_W = 30;
    localparam int PEAK_TH_W   = 15;
    localparam int RUN_W       = 16;
    localparam int SEG_W       = 32;
    localparam int MODE_W      = 2;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 30;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_TH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_TH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SILENT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ACTIVE = 2'd3;

    localparam logic [ENERGY_TH_W-1:0] ENERGY_TH_RST  = 30'd1073;
    localparam logic [PEAK_TH_W-1:0]   PEAK_TH_RST    = 15'd32;
    localparam logic [RUN_W-1:0]       MIN_SILENT_RST = 16'd10;
    localparam logic [RUN_W-1:0]       MIN_ACTIVE_RST = 16'd2;

    // classification modes
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EVEN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEAK = 2'd2;

    typedef struct packed {
        logic accept;      // latch an input transaction
        logic square;      // store sample, square it, track peak
        logic accumulate;  // add square into the sums, advance fill
        logic multiply;    // form count x energy threshold
        logic decide;      // classify block and update hysteresis
        logic rep_start;   // point replay at the first stored sample
        logic rep_next;    // advance replay
        logic clear;       // drop the block
    } bseg_cmd_t;

    typedef struct packed {
        logic fill_empty;
        logic fill_last;   // the sample being stored completes the block
        logic gate_closed;
        logic rep_last;
    } bseg_status_t;

endpackage

// ----- sv/bseg_datapath.sv -----
// Datapath of the silence gate: block memory, energy and peak
// accumulators, threshold multiply, hysteresis counters, config registers.
// Depends on bseg_pkg.
`timescale 1ns / 1ps

module bseg_datapath #(
    parameter int BLOCK_SIZE = bseg_pkg::BLOCK_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bseg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bseg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_flush,
    input  logic signed [bseg_pkg::SAMPLE_W-1:0] in_sample,
    input  logic [bseg_pkg::MODE_W-1:0]         in_mode,
    input  bseg_pkg::bseg_cmd_t                 cmd,
    output bseg_pkg::bseg_status_t              status,
    output logic signed [bseg_pkg::SAMPLE_W-1:0] out_sample,
    output logic [bseg_pkg::SEG_W-1:0]          silent_segments
);

    localparam int IDX_W  = $clog2(BLOCK_SIZE);
    localparam int CNT_W  = $clog2(BLOCK_SIZE + 1);
    localparam int MAG_W  = bseg_pkg::SAMPLE_W + 1;
    localparam int SQ_W   = 2 * bseg_pkg::SAMPLE_W - 1;
    localparam int SUM_W  = SQ_W + CNT_W;
    localparam int PROD_W = CNT_W + bseg_pkg::ENERGY_TH_W;
    localparam int RUN_W  = bseg_pkg::RUN_W;

    // configuration
    logic [bseg_pkg::ENERGY_TH_W-1:0] energy_th_reg;
    logic [bseg_pkg::PEAK_TH_W-1:0]   peak_th_reg;
    logic [RUN_W-1:0]                 min_silent_reg;
    logic [RUN_W-1:0]                 min_active_reg;

    // block state
    logic signed [bseg_pkg::SAMPLE_W-1:0] mem [BLOCK_SIZE];
    logic signed [bseg_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [bseg_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [bseg_pkg::MODE_W-1:0]          mode_reg;
    logic [CNT_W-1:0]                     fill_reg;
    logic [SQ_W-1:0]                      sq_reg;
    logic [SUM_W-1:0]                     full_sum_reg;
    logic [SUM_W-1:0]                     even_sum_reg;
    logic [MAG_W-1:0]                     peak_reg;
    logic [PROD_W-1:0]                    prod_reg;
    logic [IDX_W-1:0]                     rep_idx_reg;

    // hysteresis
    logic [RUN_W-1:0]             silent_run_reg;
    logic [RUN_W-1:0]             active_run_reg;
    logic                         gate_closed_reg;
    logic [bseg_pkg::SEG_W-1:0]   seg_count_reg;

    logic signed [MAG_W-1:0] sample_ext;
    logic [MAG_W-1:0]        mag;
    logic [2*MAG_W-1:0]      sq_full;
    logic [CNT_W:0]          half_cnt;
    logic [CNT_W-1:0]        mul_cnt;
    logic                    silent;
    logic [RUN_W-1:0]        silent_run_inc;
    logic [RUN_W-1:0]        active_run_inc;

    assign sample_ext = MAG_W'(sample_reg);
    assign mag        = sample_ext[MAG_W-1] ? MAG_W'(-sample_ext) : MAG_W'(sample_ext);
    assign sq_full    = mag * mag;

    assign half_cnt = ({1'b0, fill_reg} + (CNT_W+1)'(1)) >> 1;
    assign mul_cnt  = (mode_reg == bseg_pkg::MODE_EVEN) ? half_cnt[CNT_W-1:0] : fill_reg;

    always_comb
    begin
        case (mode_reg)
            bseg_pkg::MODE_FULL: silent = full_sum_reg <= SUM_W'(prod_reg);
            bseg_pkg::MODE_EVEN: silent = even_sum_reg <= SUM_W'(prod_reg);
            bseg_pkg::MODE_PEAK: silent = peak_reg <= MAG_W'(peak_th_reg);
            default:             silent = 1'b1;
        endcase
    end

    assign silent_run_inc = (silent_run_reg == '1) ? silent_run_reg : silent_run_reg + 1'b1;
    assign active_run_inc = (active_run_reg == '1) ? active_run_reg : active_run_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_th_reg  <= bseg_pkg::ENERGY_TH_RST;
            peak_th_reg    <= bseg_pkg::PEAK_TH_RST;
            min_silent_reg <= bseg_pkg::MIN_SILENT_RST;
            min_active_reg <= bseg_pkg::MIN_ACTIVE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bseg_pkg::CFG_ENERGY_TH:  energy_th_reg  <= cfg_data;
                bseg_pkg::CFG_PEAK_TH:    peak_th_reg    <= cfg_data[bseg_pkg::PEAK_TH_W-1:0];
                bseg_pkg::CFG_MIN_SILENT: min_silent_reg <= cfg_data[RUN_W-1:0];
                bseg_pkg::CFG_MIN_ACTIVE: min_active_reg <= cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            full_sum_reg    <= '0;
            even_sum_reg    <= '0;
            peak_reg        <= '0;
            mode_reg        <= bseg_pkg::MODE_FULL;
            rep_idx_reg     <= '0;
            silent_run_reg  <= '0;
            active_run_reg  <= '0;
            gate_closed_reg <= 1'b0;
            seg_count_reg   <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                // a flush always classifies in full-energy mode
                mode_reg <= in_flush ? bseg_pkg::MODE_FULL : in_mode;
            end
            if (cmd.square && fill_reg[1:0] == 2'b00 && mag > peak_reg)
            begin
                peak_reg <= mag;
            end
            if (cmd.accumulate)
            begin
                full_sum_reg <= full_sum_reg + SUM_W'(sq_reg);
                if (!fill_reg[0])
                begin
                    even_sum_reg <= even_sum_reg + SUM_W'(sq_reg);
                end
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.decide)
            begin
                if (silent)
                begin
                    silent_run_reg <= silent_run_inc;
                    if (!gate_closed_reg && silent_run_inc >= min_silent_reg)
                    begin
                        gate_closed_reg <= 1'b1;
                        active_run_reg  <= '0;
                        seg_count_reg   <= seg_count_reg + 1'b1;
                    end
                end
                else
                begin
                    active_run_reg <= active_run_inc;
                    if (gate_closed_reg && active_run_inc >= min_active_reg)
                    begin
                        gate_closed_reg <= 1'b0;
                        silent_run_reg  <= '0;
                    end
                end
            end
            if (cmd.rep_start)
            begin
                rep_idx_reg <= '0;
            end
            else if (cmd.rep_next)
            begin
                rep_idx_reg <= rep_idx_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                fill_reg     <= '0;
                full_sum_reg <= '0;
                even_sum_reg <= '0;
                peak_reg     <= '0;
            end
        end
    end

    // payload registers and block memory
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= in_sample;
        end
        if (cmd.square)
        begin
            mem[fill_reg[IDX_W-1:0]] <= sample_reg;
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (cmd.multiply)
        begin
            prod_reg <= mul_cnt * energy_th_reg;
        end
        rd_data_reg <= mem[rep_idx_reg];
    end

    assign status.fill_empty  = (fill_reg == '0);
    assign status.fill_last   = (fill_reg == CNT_W'(BLOCK_SIZE - 1));
    assign status.gate_closed = gate_closed_reg;
    assign status.rep_last    = ({1'b0, rep_idx_reg} + (IDX_W+1)'(1)) == (IDX_W+1)'(fill_reg);

    assign out_sample      = rd_data_reg;
    assign silent_segments = seg_count_reg;

endmodule

// ----- sv/bseg_ctrl.sv -----
// Controller of the silence gate: sequences sample intake, block
// classification and replay. Depends on bseg_pkg.
`timescale 1ns / 1ps

module bseg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_flush,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output bseg_pkg::bseg_cmd_t    cmd,
    input  bseg_pkg::bseg_status_t status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQUARE = 3'd1;
    localparam logic [2:0] S_ACCUM  = 3'd2;
    localparam logic [2:0] S_MULT   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_GATE   = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;
    localparam logic [2:0] S_SEND   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SEND);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!in_flush)
                    begin
                        state_next = S_SQUARE;
                    end
                    else if (!status.fill_empty)
                    begin
                        state_next = S_MULT;
                    end
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.accumulate = 1'b1;
                state_next     = status.fill_last ? S_MULT : S_IDLE;
            end
            S_MULT:
            begin
                cmd.multiply = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_GATE;
            end
            S_GATE:
            begin
                // closed gate: drop the block without replay
                if (status.gate_closed)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rep_start = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    if (status.rep_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rep_next = 1'b1;
                        state_next   = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/block_energy_silence_gate.sv -----
// Block-energy silence gate top level: stream ports, controller, datapath.
// Depends on bseg_pkg, bseg_ctrl and bseg_datapath.
//
// Samples are collected into a block of BLOCK_SIZE entries; when the block
// fills (or on a flush with stored samples) it is classified by full energy,
// even-sample energy or peak of every fourth sample, the hysteresis counters
// open or close the gate, and an open gate replays the block on the master
// stream with tlast on its final sample. Each sample passes the accept, square
// and accumulate states before the next ready. Closing a block passes the
// multiply, decide and gate check states, then each replayed sample passes a
// read state, for the registered read of the block memory, and a send state
// that waits while the sink holds tready low. One item is in work at a time.
`timescale 1ns / 1ps

module block_energy_silence_gate #(
    parameter int BLOCK_SIZE = bseg_pkg::BLOCK_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bseg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bseg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // sample_value
    input  logic [2:0]                        s_tuser,   // action, flow_mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // out_sample, silent_segments
    output logic                              m_tlast    // last_of_block
);

    bseg_pkg::bseg_cmd_t    cmd;
    bseg_pkg::bseg_status_t status;

    logic signed [bseg_pkg::SAMPLE_W-1:0] out_sample;
    logic [bseg_pkg::SEG_W-1:0]           silent_segments;

    bseg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_flush  (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    bseg_datapath #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_flush        (s_tuser[0]),
        .in_sample       (s_tdata),
        .in_mode         (s_tuser[2:1]),
        .cmd             (cmd),
        .status          (status),
        .out_sample      (out_sample),
        .silent_segments (silent_segments)
    );

    assign m_tdata = {silent_segments, out_sample};
    assign m_tlast = status.rep_last;

endmodule
